>>> rtl/rcd_pkg.sv
// Shared types and encodings for the RISC-V control decoder.
package rcd_pkg;

  // Major opcodes (instruction bits 6:0)
  localparam logic [6:0] OP_LOAD     = 7'h03;
  localparam logic [6:0] OP_LOAD_FP  = 7'h07;
  localparam logic [6:0] OP_MISC_MEM = 7'h0f;
  localparam logic [6:0] OP_IMM      = 7'h13;
  localparam logic [6:0] OP_AUIPC    = 7'h17;
  localparam logic [6:0] OP_IMM_32   = 7'h1b;
  localparam logic [6:0] OP_STORE    = 7'h23;
  localparam logic [6:0] OP_STORE_FP = 7'h27;
  localparam logic [6:0] OP_AMO      = 7'h2f;
  localparam logic [6:0] OP_OP       = 7'h33;
  localparam logic [6:0] OP_LUI      = 7'h37;
  localparam logic [6:0] OP_OP_32    = 7'h3b;
  localparam logic [6:0] OP_MADD     = 7'h43;
  localparam logic [6:0] OP_MSUB     = 7'h47;
  localparam logic [6:0] OP_NMSUB    = 7'h4b;
  localparam logic [6:0] OP_NMADD    = 7'h4f;
  localparam logic [6:0] OP_OP_FP    = 7'h53;
  localparam logic [6:0] OP_BRANCH   = 7'h63;
  localparam logic [6:0] OP_JALR     = 7'h67;
  localparam logic [6:0] OP_JAL      = 7'h6f;
  localparam logic [6:0] OP_SYSTEM   = 7'h73;

  // FP-op groups: funct7 with bit 0 cleared
  localparam logic [6:0] GRP_ARITH_MAX = 7'h14;
  localparam logic [6:0] GRP_FCMP      = 7'h50;
  localparam logic [6:0] GRP_FCVT_TO_X = 7'h60;
  localparam logic [6:0] GRP_FCVT_FR_X = 7'h68;
  localparam logic [6:0] GRP_FMV_TO_X  = 7'h70;
  localparam logic [6:0] GRP_FMV_FR_X  = 7'h78;

  // AMO funct5 for load-reserved
  localparam logic [4:0] FUNCT5_LR = 5'h02;

  // Register class codes
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_INT  = 2'd1;
  localparam logic [1:0] CLS_FP   = 2'd2;

  // Memory kind codes
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;
  localparam logic [1:0] MEM_AMO   = 2'd3;

  // Request: one instruction to decode
  typedef struct packed {
    logic [31:0] instruction_word;
    logic        trap_pending;
  } req_t;

  // Decoded control word
  typedef struct packed {
    logic [4:0] dest_reg;
    logic [4:0] src1_reg;
    logic [4:0] src2_reg;
    logic [4:0] src3_reg;
    logic [1:0] write_class;
    logic [1:0] src1_class;
    logic [1:0] src2_class;
    logic       src3_fp_used;
    logic [1:0] mem_kind;
    logic [3:0] access_bytes;
    logic       serializing;
    logic       illegal;
  } rsp_t;

endpackage

>>> rtl/rcd_decode.sv
// Combinational decode of one instruction into its control word.
module rcd_decode (
  input  rcd_pkg::req_t req,
  output rcd_pkg::rsp_t rsp
);
  import rcd_pkg::*;

  logic [31:0] w;
  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  grp;
  logic [3:0]  msize;
  rsp_t        dec;

  assign w     = req.instruction_word;
  assign op    = w[6:0];
  assign f3    = w[14:12];
  assign grp   = {w[31:26], 1'b0};
  assign msize = 4'b0001 << f3[1:0];

  // Opcode decode; all flags default to zero
  always_comb begin
    dec              = '0;
    dec.dest_reg     = w[11:7];
    dec.src1_reg     = w[19:15];
    dec.src2_reg     = w[24:20];
    dec.src3_reg     = w[31:27];
    unique case (op) inside
      OP_LUI, OP_AUIPC, OP_JAL: begin
        dec.write_class = CLS_INT;
      end
      OP_JALR, OP_IMM, OP_IMM_32: begin
        dec.write_class = CLS_INT;
        dec.src1_class  = CLS_INT;
      end
      OP_OP, OP_OP_32: begin
        dec.write_class = CLS_INT;
        dec.src1_class  = CLS_INT;
        dec.src2_class  = CLS_INT;
      end
      OP_BRANCH: begin
        dec.src1_class = CLS_INT;
        dec.src2_class = CLS_INT;
      end
      OP_LOAD: begin
        dec.write_class  = CLS_INT;
        dec.src1_class   = CLS_INT;
        dec.mem_kind     = MEM_LOAD;
        dec.access_bytes = msize;
      end
      OP_STORE: begin
        dec.src1_class   = CLS_INT;
        dec.src2_class   = CLS_INT;
        dec.mem_kind     = MEM_STORE;
        dec.access_bytes = msize;
      end
      OP_LOAD_FP: begin
        dec.write_class  = CLS_FP;
        dec.src1_class   = CLS_INT;
        dec.mem_kind     = MEM_LOAD;
        dec.access_bytes = msize;
      end
      OP_STORE_FP: begin
        dec.src1_class   = CLS_INT;
        dec.src2_class   = CLS_FP;
        dec.mem_kind     = MEM_STORE;
        dec.access_bytes = msize;
      end
      OP_AMO: begin
        dec.write_class  = CLS_INT;
        dec.src1_class   = CLS_INT;
        dec.serializing  = 1'b1;
        dec.access_bytes = msize;
        // load-reserved reads memory only and has no rs2
        if (w[31:27] != FUNCT5_LR) begin
          dec.mem_kind   = MEM_AMO;
          dec.src2_class = CLS_INT;
        end else begin
          dec.mem_kind   = MEM_LOAD;
        end
      end
      OP_MISC_MEM: begin
        dec.serializing = 1'b1;
      end
      OP_SYSTEM: begin
        dec.serializing = 1'b1;
        if (f3 != 3'd0) dec.write_class = CLS_INT;
        // CSR ops with register source
        if (f3 != 3'd0 && !f3[2]) dec.src1_class = CLS_INT;
      end
      OP_MADD, OP_MSUB, OP_NMSUB, OP_NMADD: begin
        dec.write_class  = CLS_FP;
        dec.src1_class   = CLS_FP;
        dec.src2_class   = CLS_FP;
        dec.src3_fp_used = 1'b1;
      end
      OP_OP_FP: begin
        dec.write_class = CLS_FP;
        dec.src1_class  = CLS_FP;
        if (grp <= GRP_ARITH_MAX || grp == GRP_FCMP) dec.src2_class = CLS_FP;
        if (grp == GRP_FCVT_TO_X || grp == GRP_FMV_TO_X || grp == GRP_FCMP)
          dec.write_class = CLS_INT;
        if (grp == GRP_FCVT_FR_X || grp == GRP_FMV_FR_X) dec.src1_class = CLS_INT;
      end
      default: begin
        dec.illegal = 1'b1;
      end
    endcase
  end

  // Pending trap squashes the whole word
  assign rsp = req.trap_pending ? '0 : dec;

endmodule

>>> rtl/riscv_control_decoder_unit.sv
// Top level: request register, decode, and result register of the control decoder.
//
//   channel | signals                  | direction | payload
//   --------+--------------------------+-----------+----------------
//   request | req_valid, req_stall     | in        | req (req_t)
//   result  | rsp_valid, rsp_stall     | out       | rsp (rsp_t)
//
// One request per cycle unless the result stalls; rsp_valid rises once a request
// has passed the request register, then the result register behind the decode logic.
// rst is synchronous and clears both stage valids; payload registers are not reset.
// A stalled result holds; the request register keeps accepting while it can drain,
// so req_stall rises only when both stages are full and rsp_stall is high.
module riscv_control_decoder_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rcd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rcd_pkg::rsp_t rsp
);
  import rcd_pkg::*;

  logic s1_valid;
  req_t s1_req;
  rsp_t dec_rsp;
  logic s1_ready;
  logic s2_ready;

  // Stage readiness
  assign s2_ready  = !rsp_valid || !rsp_stall;
  assign s1_ready  = !s1_valid || s2_ready;
  assign req_stall = !s1_ready;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && s1_ready) s1_req <= req;
  end

  rcd_decode u_decode (
    .req (s1_req),
    .rsp (dec_rsp)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s2_ready) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) rsp <= dec_rsp;
  end

  // An accepted request lands in the request register
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> s1_valid)
    else $error("accepted request lost");

  // A blocked request register holds its request
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(s1_req))
    else $error("request register changed while blocked");

  // Trap-pending request yields an all-zero result
  a_trap_zero: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready && s1_req.trap_pending |=> rsp_valid && rsp == '0)
    else $error("trap-pending result not zero");

  // Illegal opcode carries no other control
  a_illegal_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.illegal |-> rsp.mem_kind == MEM_NONE &&
      rsp.write_class == CLS_NONE && !rsp.serializing && rsp.access_bytes == 4'd0)
    else $error("illegal result carries control bits");

endmodule

>>> test/tb.sv
// Self-checking testbench for riscv_control_decoder_unit under idling and backpressure.
module tb;
  import rcd_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_PRINTED = 60;
  localparam int RANDOM_PER_PHASE = 200;

  // One decode waiting for its result
  typedef struct {
    req_t word_in;
    rsp_t controls;
  } decode_due_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  decode_due_t controls_due[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  riscv_control_decoder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // Expected control word for one instruction
  function automatic rsp_t predict_controls(input req_t r);
    rsp_t e;
    logic [31:0] w;
    logic [2:0] f3;
    logic [3:0] size;
    logic [6:0] grp;
    e = '0;
    w = r.instruction_word;
    if (r.trap_pending) return e;
    f3 = w[14:12];
    size = 4'd1 << f3[1:0];
    grp = {w[31:26], 1'b0};
    e.dest_reg = w[11:7];
    e.src1_reg = w[19:15];
    e.src2_reg = w[24:20];
    e.src3_reg = w[31:27];
    case (w[6:0])
      OP_LUI, OP_AUIPC, OP_JAL: e.write_class = CLS_INT;
      OP_JALR, OP_IMM, OP_IMM_32: begin
        e.write_class = CLS_INT;
        e.src1_class = CLS_INT;
      end
      OP_OP, OP_OP_32: begin
        e.write_class = CLS_INT;
        e.src1_class = CLS_INT;
        e.src2_class = CLS_INT;
      end
      OP_BRANCH: begin
        e.src1_class = CLS_INT;
        e.src2_class = CLS_INT;
      end
      OP_LOAD: begin
        e.write_class = CLS_INT;
        e.src1_class = CLS_INT;
        e.mem_kind = MEM_LOAD;
        e.access_bytes = size;
      end
      OP_STORE: begin
        e.src1_class = CLS_INT;
        e.src2_class = CLS_INT;
        e.mem_kind = MEM_STORE;
        e.access_bytes = size;
      end
      OP_LOAD_FP: begin
        e.write_class = CLS_FP;
        e.src1_class = CLS_INT;
        e.mem_kind = MEM_LOAD;
        e.access_bytes = size;
      end
      OP_STORE_FP: begin
        e.src1_class = CLS_INT;
        e.src2_class = CLS_FP;
        e.mem_kind = MEM_STORE;
        e.access_bytes = size;
      end
      OP_AMO: begin
        e.write_class = CLS_INT;
        e.src1_class = CLS_INT;
        e.serializing = 1'b1;
        e.access_bytes = size;
        // load-reserved reads memory only and ignores rs2
        if (w[31:27] != FUNCT5_LR) begin
          e.mem_kind = MEM_AMO;
          e.src2_class = CLS_INT;
        end else begin
          e.mem_kind = MEM_LOAD;
        end
      end
      OP_MISC_MEM: e.serializing = 1'b1;
      OP_SYSTEM: begin
        e.serializing = 1'b1;
        if (f3 != 3'd0) e.write_class = CLS_INT;
        if (f3 != 3'd0 && f3 < 3'd4) e.src1_class = CLS_INT;
      end
      OP_MADD, OP_MSUB, OP_NMSUB, OP_NMADD: begin
        e.write_class = CLS_FP;
        e.src1_class = CLS_FP;
        e.src2_class = CLS_FP;
        e.src3_fp_used = 1'b1;
      end
      OP_OP_FP: begin
        e.write_class = CLS_FP;
        e.src1_class = CLS_FP;
        if (grp <= GRP_ARITH_MAX || grp == GRP_FCMP) e.src2_class = CLS_FP;
        if (grp == GRP_FCVT_TO_X || grp == GRP_FMV_TO_X || grp == GRP_FCMP)
          e.write_class = CLS_INT;
        if (grp == GRP_FCVT_FR_X || grp == GRP_FMV_FR_X) e.src1_class = CLS_INT;
      end
      default: e.illegal = 1'b1;
    endcase
    return e;
  endfunction

  function automatic logic [6:0] opcode_at(input int i);
    case (i)
      0:  return OP_LOAD;
      1:  return OP_LOAD_FP;
      2:  return OP_MISC_MEM;
      3:  return OP_IMM;
      4:  return OP_AUIPC;
      5:  return OP_IMM_32;
      6:  return OP_STORE;
      7:  return OP_STORE_FP;
      8:  return OP_AMO;
      9:  return OP_OP;
      10: return OP_LUI;
      11: return OP_OP_32;
      12: return OP_MADD;
      13: return OP_MSUB;
      14: return OP_NMSUB;
      15: return OP_NMADD;
      16: return OP_OP_FP;
      17: return OP_BRANCH;
      18: return OP_JALR;
      19: return OP_JAL;
      default: return OP_SYSTEM;
    endcase
  endfunction

  function automatic logic [6:0] fp_group_at(input int i);
    case (i)
      0: return GRP_ARITH_MAX;
      1: return GRP_FCMP;
      2: return GRP_FCVT_TO_X;
      3: return GRP_FCVT_FR_X;
      4: return GRP_FMV_TO_X;
      default: return GRP_FMV_FR_X;
    endcase
  endfunction

  // Instruction with the given opcode and random upper bits
  function automatic req_t instr_with(input logic [6:0] op, input logic trap);
    req_t r;
    r.instruction_word = $urandom;
    r.instruction_word[6:0] = op;
    r.trap_pending = trap;
    return r;
  endfunction

  // Mostly well-formed instructions, some noise and some trapped
  function automatic req_t random_request();
    req_t r;
    r = instr_with(opcode_at($urandom_range(0, 20)), $urandom_range(0, 99) < 8);
    if ($urandom_range(0, 99) < 10) r.instruction_word = $urandom;
    if (r.instruction_word[6:0] == OP_OP_FP && $urandom_range(0, 1) == 1)
      r.instruction_word[31:25] = fp_group_at($urandom_range(0, 5)) | 7'($urandom_range(0, 1));
    if (r.instruction_word[6:0] == OP_AMO && $urandom_range(0, 2) == 0)
      r.instruction_word[31:27] = FUNCT5_LR;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want, input req_t r);
    if (errors < MAX_PRINTED)
      $display("mismatch %s: got %0h want %0h (instr %h trap %b)",
               what, got, want, r.instruction_word, r.trap_pending);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input req_t r);
    if (got !== want) report_mismatch(name, got, want, r);
  endtask

  // Match one result against the oldest pending decode
  task automatic check_decode(input rsp_t got);
    decode_due_t due;
    rsp_t want;
    req_t r;
    if (controls_due.size() == 0) begin
      report_mismatch("result with no request pending", 32'(got), '0, '0);
      return;
    end
    due = controls_due.pop_front();
    want = due.controls;
    r = due.word_in;
    compare_field("dest_reg", 32'(got.dest_reg), 32'(want.dest_reg), r);
    compare_field("src1_reg", 32'(got.src1_reg), 32'(want.src1_reg), r);
    compare_field("src2_reg", 32'(got.src2_reg), 32'(want.src2_reg), r);
    compare_field("src3_reg", 32'(got.src3_reg), 32'(want.src3_reg), r);
    compare_field("write_class", 32'(got.write_class), 32'(want.write_class), r);
    compare_field("src1_class", 32'(got.src1_class), 32'(want.src1_class), r);
    compare_field("src2_class", 32'(got.src2_class), 32'(want.src2_class), r);
    compare_field("src3_fp_used", 32'(got.src3_fp_used), 32'(want.src3_fp_used), r);
    compare_field("mem_kind", 32'(got.mem_kind), 32'(want.mem_kind), r);
    compare_field("access_bytes", 32'(got.access_bytes), 32'(want.access_bytes), r);
    compare_field("serializing", 32'(got.serializing), 32'(want.serializing), r);
    compare_field("illegal", 32'(got.illegal), 32'(want.illegal), r);
  endtask

  // Offer one request, with random gaps, and hold it until accepted
  task automatic send_request(input req_t r);
    decode_due_t due;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    due.word_in = r;
    due.controls = predict_controls(r);
    controls_due.push_back(due);
  endtask

  // Result side: random stalls, or a long hold when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) check_decode(rsp);
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** riscv_control_decoder_unit: FAILED **");
      $finish;
    end
  end

  // All-zero, all-one and trapped words
  task automatic test_field_extremes();
    req_t r;
    r.instruction_word = 32'h0000_0000;
    r.trap_pending = 1'b0;
    send_request(r);
    r.instruction_word = 32'hffff_ffff;
    send_request(r);
    r.trap_pending = 1'b1;
    send_request(r);
    send_request(instr_with(OP_LOAD, 1'b1));
  endtask

  // Every major opcode once
  task automatic test_each_opcode();
    for (int i = 0; i <= 20; i++) send_request(instr_with(opcode_at(i), 1'b0));
  endtask

  // Load-reserved, FP-op groups and system funct3 corners
  task automatic test_special_cases();
    req_t r;
    r = instr_with(OP_AMO, 1'b0);
    r.instruction_word[31:27] = FUNCT5_LR;
    send_request(r);
    for (int g = 0; g <= 5; g++) begin
      r = instr_with(OP_OP_FP, 1'b0);
      r.instruction_word[31:25] = fp_group_at(g) | 7'(g & 1);
      send_request(r);
    end
    // just above the arithmetic groups: FP write, no rs2
    r = instr_with(OP_OP_FP, 1'b0);
    r.instruction_word[31:25] = GRP_ARITH_MAX + 7'd2;
    send_request(r);
    r = instr_with(OP_SYSTEM, 1'b0);
    r.instruction_word[14:12] = 3'd0;
    send_request(r);
    r.instruction_word[14:12] = 3'd4;
    send_request(r);
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_chance);
    send_idle_pct = idle_pct;
    stall_pct = stall_chance;
    for (int i = 0; i < count; i++) send_request(random_request());
  endtask

  task automatic test_random_no_idle();
    run_random(RANDOM_PER_PHASE, 0, 0);
  endtask

  task automatic test_random_sender_gaps();
    run_random(RANDOM_PER_PHASE, 75, 0);
  endtask

  task automatic test_random_receiver_stalls();
    run_random(RANDOM_PER_PHASE, 0, 75);
  endtask

  task automatic test_random_both_idle();
    run_random(RANDOM_PER_PHASE, 24, 24);
  endtask

  // Long result hold while requests keep coming, so the input backs up
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left <= 300;
    for (int i = 0; i < 20; i++) send_request(random_request());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_each_opcode();
    test_special_cases();
    test_random_no_idle();
    test_random_sender_gaps();
    test_backpressure();
    test_random_receiver_stalls();
    test_random_both_idle();
    req_valid <= 1'b0;
    stall_pct = 0;
    while (controls_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** riscv_control_decoder_unit: PASSED **");
    end else begin
      $display("** riscv_control_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/rcd_pkg.sv
rtl/rcd_decode.sv
rtl/riscv_control_decoder_unit.sv
test/tb.sv
